// ===== design/qtp_pkg.sv =====
`default_nettype none
package qtp_pkg;

  localparam int CMD_W     = 2;
  localparam int PATH_W    = 14;
  localparam int ROW_IDX_W = 6;
  localparam int PIX_W     = 64;
  localparam int SLOG_W    = 3;

  localparam logic [SLOG_W-1:0] SIDE_LOG2_RESET = 3'd6;

  // n / 5 as (n * DIV5_MUL) >> DIV5_SHIFT, exact for every 14-bit n
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PAINT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    DIG_STAY = 3'd0,
    DIG_NW   = 3'd1,
    DIG_NE   = 3'd2,
    DIG_SW   = 3'd3,
    DIG_SE   = 3'd4
  } digit_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/qtp_ifs.sv =====
`default_nettype none
interface qtp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [13:0] path_number;
  logic [5:0]  row_index;

  modport source (output valid, command, path_number, row_index, input ready);
  modport sink   (input valid, command, path_number, row_index, output ready);
endinterface

interface qtp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_pixels;
  logic [5:0]  row_number;

  modport source (output valid, row_pixels, row_number, input ready);
  modport sink   (input valid, row_pixels, row_number, output ready);
endinterface

interface qtp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] side_log2;

  modport source (output valid, side_log2, input ready);
  modport sink   (input valid, side_log2, output ready);
endinterface
`default_nettype wire

// ===== design/qtp_cell.sv =====
`default_nettype none
module qtp_cell #(
  parameter int W = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire qtp_pkg::cell_ctrl_t ctrl,
  input  wire logic [W-1:0]        din,
  output logic      [W-1:0]        q
);
  import qtp_pkg::*;

  logic [W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      row_r <= '0;
    end else if (ctrl.shift) begin
      row_r <= din;
    end
  end

  assign q = row_r;

endmodule
`default_nettype wire

// ===== design/qtp_digit.sv =====
`default_nettype none
module qtp_digit (
  input  wire logic [qtp_pkg::PATH_W-1:0] num,
  output logic      [qtp_pkg::PATH_W-1:0] quot,
  output qtp_pkg::digit_t                 digit
);
  import qtp_pkg::*;

  logic [PATH_W+15:0] prod;
  logic [2:0]         rem;

  always_comb begin
    prod  = {16'd0, num} * {{PATH_W{1'b0}}, DIV5_MUL};
    quot  = PATH_W'(prod >> DIV5_SHIFT);
    rem   = 3'(num - ((quot << 2) + quot));
    digit = digit_t'(rem);
  end

endmodule
`default_nettype wire

// ===== design/quadtree_path_to_bitmap_painter.sv =====
`default_nettype none
// Quadtree path painter over a square bitmap held in a ring of row cells.
//
// in_if carries one transaction per command: clear, paint a base-5 quadtree
// path, or read a row. cfg_if writes side_log2; write it only while idle.
// out_if returns one transaction per read: the row's pixels and its number.
//
// Operation, with R = min(SIDE, 64) stored rows:
//   clear: every cell zeroes at once.
//   paint: digit decode (one base-5 digit per cycle through the reciprocal
//          divider, at most MAX_DIGITS digits), then one turn of the ring
//          in which each row is OR-ed with the square's mask as it
//          passes the head cell.
//   read:  one turn of the ring over the R rows, then the captured row goes
//          into the output register.
// The ring revolution sets the pace of paints and reads; a clear or unknown
// command leaves the block idle.
// in_if.ready is high only between items. A finished row sits in the output
// register; if the receiver stalls while a second read completes, that read
// holds until out_if.ready, then the block goes back to accepting items.
// Reset zeroes the bitmap and sets side_log2 to 6.
module quadtree_path_to_bitmap_painter #(
  parameter int SIDE       = 64,
  parameter int MAX_DIGITS = 6
) (
  input wire logic   clk,
  input wire logic   rst_n,
  qtp_in_if.sink     in_if,
  qtp_out_if.source  out_if,
  qtp_cfg_if.sink    cfg_if
);
  import qtp_pkg::*;

  localparam int DIM = (SIDE < 64) ? SIDE : 64;
  localparam int CW  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KW  = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_HOLD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOG_W-1:0] side_log2_r;
  logic [8:0]        side_pow, side;

  logic [PATH_W-1:0]    num_r;
  logic [KW-1:0]        k_r;
  logic [8:0]           reg_row_r, reg_col_r, reg_len_r;
  logic                 op_read_r;
  logic [ROW_IDX_W-1:0] rix_r;
  logic [CW-1:0]        t_r;
  logic [DIM-1:0]       cap_r;

  logic [PIX_W-1:0]     out_pix_r;
  logic [ROW_IDX_W-1:0] out_num_r;
  logic                 out_valid_r;

  logic              in_acc;
  cmd_t              in_cmd;
  logic              dec_done;
  logic [PATH_W-1:0] quot;
  digit_t            digit;
  logic [8:0]        half;
  logic              sweep_last;
  logic              hold_go;

  logic [9:0]     row_end, col_end, t_ext;
  logic           hit;
  logic [DIM-1:0] col_mask;
  logic [DIM-1:0] head_new;
  logic [PIX_W-1:0] cap_ext, read_pix;
  logic           row_ok;

  cell_ctrl_t             ctrl;
  logic [DIM-1:0][DIM-1:0] row_q;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign in_cmd       = cmd_t'(in_if.command);

  always_comb begin
    side_pow = 9'd1 << side_log2_r;
    side     = (side_pow > 9'(SIDE)) ? 9'(SIDE) : side_pow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r <= SIDE_LOG2_RESET;
    end else if (cfg_if.valid) begin
      side_log2_r <= cfg_if.side_log2;
    end
  end

  qtp_digit u_digit (
    .num   (num_r),
    .quot  (quot),
    .digit (digit)
  );

  assign dec_done   = (num_r == '0) || (k_r == KW'(MAX_DIGITS));
  assign half       = reg_len_r >> 1;
  assign sweep_last = (t_r == CW'(DIM - 1));
  assign hold_go    = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_PAINT) begin
          state_nxt = ST_DECODE;
        end else if (in_acc && in_cmd == CMD_READ) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_DECODE: if (dec_done) state_nxt = ST_SWEEP;
      ST_SWEEP:  if (sweep_last) state_nxt = op_read_r ? ST_HOLD : ST_IDLE;
      ST_HOLD:   if (hold_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Digit decode and sweep bookkeeping
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        num_r     <= in_if.path_number;
        k_r       <= '0;
        reg_row_r <= '0;
        reg_col_r <= '0;
        reg_len_r <= side;
        op_read_r <= (in_cmd == CMD_READ);
        rix_r     <= in_if.row_index;
        t_r       <= '0;
        cap_r     <= '0;
      end
      ST_DECODE: begin
        if (!dec_done) begin
          num_r <= quot;
          k_r   <= k_r + KW'(1);
          if (digit != DIG_STAY) begin
            reg_len_r <= half;
            if (digit == DIG_NE || digit == DIG_SE) reg_col_r <= reg_col_r + half;
            if (digit == DIG_SW || digit == DIG_SE) reg_row_r <= reg_row_r + half;
          end
        end
      end
      ST_SWEEP: begin
        t_r <= t_r + CW'(1);
        if (ROW_IDX_W'(t_r) == rix_r) cap_r <= row_q[0];
      end
      default: ;
    endcase
  end

  // Paint mask for the row at the head cell
  always_comb begin
    row_end = {1'b0, reg_row_r} + {1'b0, reg_len_r};
    col_end = {1'b0, reg_col_r} + {1'b0, reg_len_r};
    t_ext   = 10'(t_r);
    hit     = !op_read_r && (t_ext >= {1'b0, reg_row_r}) && (t_ext < row_end);
    for (int j = 0; j < DIM; j++) begin
      col_mask[j] = (10'(j) >= {1'b0, reg_col_r}) && (10'(j) < col_end);
    end
    head_new = hit ? (row_q[0] | col_mask) : row_q[0];
  end

  assign ctrl.shift = (state_r == ST_SWEEP);
  assign ctrl.clear = in_acc && (in_cmd == CMD_CLEAR);

  for (genvar i = 0; i < DIM; i++) begin : g_cell
    logic [DIM-1:0] din;
    if (i == DIM - 1) begin : g_tail
      assign din = head_new;
    end else begin : g_link
      assign din = row_q[i+1];
    end
    qtp_cell #(.W(DIM)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .din   (din),
      .q     (row_q[i])
    );
  end

  // Trim the captured row to the current side
  always_comb begin
    cap_ext = PIX_W'(cap_r);
    row_ok  = ({3'b000, rix_r} < side);
    for (int j = 0; j < PIX_W; j++) begin
      read_pix[j] = row_ok && (10'(j) < {1'b0, side}) && cap_ext[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && hold_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HOLD && hold_go) begin
      out_pix_r <= read_pix;
      out_num_r <= rix_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.row_pixels = out_pix_r;
  assign out_if.row_number = out_num_r;

endmodule
`default_nettype wire

// ===== design/qtp_checker.sv =====
`default_nettype none
module qtp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_command,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_row_pixels,
  input wire logic [5:0]  out_row_number
);
  import qtp_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_pixels)
      && $stable(out_row_number))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // Clear leaves in_ready high in the next cycle
  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_CLEAR |=> in_ready)
    else $error("clear did not return to idle");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_PAINT || in_command == CMD_READ)
      |=> !in_ready)
    else $error("paint or read accepted without going busy");

endmodule

bind quadtree_path_to_bitmap_painter qtp_checker u_qtp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_command     (in_if.command),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_row_pixels (out_if.row_pixels),
  .out_row_number (out_if.row_number)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import qtp_pkg::*;

  localparam int SIDE       = 64;
  localparam int MAX_DIGITS = 6;
  localparam int DRAIN      = SIDE + MAX_DIGITS + 24;
  localparam int LONG_HOLD  = 300;
  localparam int LIMIT      = 600000;

  typedef struct {
    logic [PIX_W-1:0]     pixels;
    logic [ROW_IDX_W-1:0] row;
  } row_result_t;

  logic clk;
  logic rst_n;

  qtp_in_if  in_bus ();
  qtp_out_if out_bus ();
  qtp_cfg_if cfg_bus ();

  quadtree_path_to_bitmap_painter #(
    .SIDE       (SIDE),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // shadow of the block's bitmap and register
  logic [PIX_W-1:0]  shadow_rows [SIDE];
  logic [SLOG_W-1:0] shadow_side_log2;
  row_result_t       pending_rows [$];

  int  errors       = 0;
  int  rows_checked = 0;
  int  items_sent   = 0;
  int  cycles       = 0;
  bit  jitter_on    = 1'b1;
  bit  hold_req     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d rows still expected", $time, pending_rows.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned image_side();
    int unsigned s;
    s = 1 << shadow_side_log2;
    return (s > SIDE) ? SIDE : s;
  endfunction

  function automatic void blank_bitmap();
    foreach (shadow_rows[i]) shadow_rows[i] = '0;
  endfunction

  // walk the base-5 digits low first and blacken the square they land on
  function automatic void paint_quadrant(logic [PATH_W-1:0] path);
    int unsigned num, r, c, len, half;
    digit_t d;
    logic [PIX_W-1:0] mask;
    num = path;
    r = 0;
    c = 0;
    len = image_side();
    for (int k = 0; k < MAX_DIGITS && num != 0; k++) begin
      d = digit_t'(num % 5);
      num = num / 5;
      half = len / 2;
      if (d == DIG_STAY) continue;
      if (d == DIG_NE || d == DIG_SE) c += half;
      if (d == DIG_SW || d == DIG_SE) r += half;
      len = half;
    end
    if (len == 0) return;
    mask = '0;
    for (int j = c; j < c + len && j < SIDE; j++) mask[j] = 1'b1;
    for (int i = r; i < r + len && i < SIDE; i++) shadow_rows[i] |= mask;
  endfunction

  function automatic row_result_t visible_row(logic [ROW_IDX_W-1:0] rix);
    row_result_t res;
    int unsigned s;
    s = image_side();
    res.row = rix;
    res.pixels = '0;
    if (rix < s) begin
      res.pixels = shadow_rows[rix];
      if (s < PIX_W) res.pixels &= (64'd1 << s) - 64'd1;
    end
    return res;
  endfunction

  function automatic logic [PATH_W-1:0] make_path(int depth);
    int unsigned n, w;
    n = 0;
    w = 1;
    for (int k = 0; k < depth; k++) begin
      n += $urandom_range(0, 4) * w;
      w *= 5;
    end
    return PATH_W'(n);
  endfunction

  task automatic send_item(cmd_t cmd, logic [PATH_W-1:0] path, logic [ROW_IDX_W-1:0] rix);
    int gap;
    gap = 0;
    if (jitter_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.command     <= cmd;
    in_bus.path_number <= path;
    in_bus.row_index   <= rix;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    case (cmd)
      CMD_CLEAR: blank_bitmap();
      CMD_PAINT: paint_quadrant(path);
      CMD_READ:  pending_rows.insert(pending_rows.size(), visible_row(rix));
      default: ;
    endcase
  endtask

  // drop valid, wait out every read, then let a paint still in flight finish
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_side(logic [SLOG_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.side_log2 <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    shadow_side_log2 = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // receiver: long hold on request, random stall bursts otherwise
  initial begin
    int stall;
    int held;
    stall = 0;
    held = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held == 0) held = LONG_HOLD;
      if (held > 0) begin
        out_bus.ready <= 1'b0;
        held--;
        if (held == 0) hold_req = 1'b0;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else if (jitter_on && $urandom_range(0, 6) == 0) begin
        out_bus.ready <= 1'b0;
        stall = $urandom_range(1, 18) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each row transaction with the oldest expected row
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row %0d pixels %h", $time, out_bus.row_number,
                 out_bus.row_pixels);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_bus.row_number !== want.row) begin
          $display("%0t: row_number expected %0d got %0d", $time, want.row,
                   out_bus.row_number);
          errors++;
        end
        if (out_bus.row_pixels !== want.pixels) begin
          $display("%0t: row %0d pixels expected %h got %h", $time, want.row, want.pixels,
                   out_bus.row_pixels);
          errors++;
        end
      end
    end
  end

  task automatic test_after_reset();
    send_item(CMD_READ, '0, 6'd0);
    send_item(CMD_READ, 14'h3fff, 6'd63);
  endtask

  task automatic test_paint_paths();
    send_item(CMD_PAINT, 14'd0, 6'd0);       // no digits: whole image
    send_item(CMD_READ, '0, 6'd5);
    send_item(CMD_CLEAR, 14'h3fff, 6'd63);
    send_item(CMD_READ, '0, 6'd5);
    send_item(CMD_PAINT, 14'd15624, 6'd0);   // six SE steps: one corner pixel
    send_item(CMD_READ, '0, 6'd63);
    send_item(CMD_PAINT, 14'd16383, 6'd0);   // digits above the sixth are dropped
    send_item(CMD_PAINT, 14'd385, 6'd0);     // stay digits mixed in
    send_item(CMD_READ, '0, 6'd32);
    send_item(CMD_READ, '0, 6'd0);
    send_item(CMD_NONE, 14'h2aaa, 6'd21);    // ignored, no row back
    send_item(CMD_READ, '0, 6'd40);
  endtask

  task automatic test_side_settings();
    write_side(3'd2);
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_PAINT, 14'd0, '0);
    send_item(CMD_READ, '0, 6'd3);
    send_item(CMD_READ, '0, 6'd4);           // beyond the side
    send_item(CMD_PAINT, 14'd31, '0);        // walks past the last level
    write_side(3'd7);                        // clamps to the full side
    send_item(CMD_READ, '0, 6'd3);
    write_side(3'd0);
    send_item(CMD_READ, '0, 6'd0);
  endtask

  // stall the receiver while reads pile up, then wait for every row
  task automatic test_backpressure();
    bit saved;
    settle();
    saved = jitter_on;
    jitter_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) send_item(CMD_READ, '0, ROW_IDX_W'($urandom));
    settle();
    jitter_on = saved;
  endtask

  task automatic test_random_traffic(int count);
    int done, pick, maxd, depth;
    cmd_t cmd;
    logic [PATH_W-1:0] path;
    logic [ROW_IDX_W-1:0] rix;
    done = 0;
    maxd = (shadow_side_log2 + 1 > MAX_DIGITS) ? MAX_DIGITS : shadow_side_log2 + 1;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      path = PATH_W'($urandom);
      rix = ROW_IDX_W'($urandom);
      if (pick < 7) begin
        cmd = CMD_CLEAR;
      end else if (pick < 11) begin
        cmd = CMD_NONE;
      end else if (pick < 55) begin
        cmd = CMD_PAINT;
        if ($urandom_range(0, 4) != 0) begin
          depth = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, maxd);
          path = make_path(depth);
        end
      end else begin
        cmd = CMD_READ;
        if ($urandom_range(0, 6) != 0) rix = ROW_IDX_W'($urandom_range(0, image_side() - 1));
      end
      send_item(cmd, path, rix);
      if (cmd != CMD_NONE) done++;
    end
  endtask

  initial begin
    logic [SLOG_W-1:0] sides [8];
    sides = '{3'd6, 3'd3, 3'd0, 3'd7, 3'd5, 3'd1, 3'd4, 3'd2};
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_CLEAR;
    in_bus.path_number = '0;
    in_bus.row_index = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.side_log2 = SIDE_LOG2_RESET;
    blank_bitmap();
    shadow_side_log2 = SIDE_LOG2_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_paint_paths();
    test_side_settings();
    write_side(3'd6);
    test_backpressure();
    foreach (sides[i]) begin
      write_side(sides[i]);
      test_random_traffic(70);
    end
    jitter_on = 1'b0;
    write_side(3'd6);
    test_random_traffic(80);
    settle();

    $display("Sent %0d transactions (clear, paint, read, ignored) over side_log2 0 to 7;",
             items_sent);
    $display("checked %0d rows, including a long receiver hold with the input stalled.",
             rows_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
